FILE: sv/pwa_pkg.sv
// ----------------------------------------------------------------------------
// pwa_pkg - shared types and constants of the pulse width averager
// Ring depth, derived widths, register map and sequencer state codes.
// ----------------------------------------------------------------------------
package pwa_pkg;

	// ring depth, 1 to 64
	localparam int SAMPLE_DEPTH = 8;

	localparam int SLOT_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(SAMPLE_DEPTH + 1);
	localparam int SAMPLE_W = 16;
	localparam int SUM_W   = SAMPLE_W + COUNT_W;

	// converter mapping: 1000 + code * 1000 / 4095, divide by 2^12 - 1 done
	// with a shift and add
	localparam int ADC_W      = 12;
	localparam int ADC_PROD_W = 22;
	localparam int DIV_W      = (SUM_W > ADC_PROD_W) ? SUM_W : ADC_PROD_W;
	localparam int DVS_W      = ADC_W;
	localparam int DCNT_W     = $clog2(DIV_W + 1);

	localparam logic [DIV_W-1:0]    ADC_SCALE  = DIV_W'(1000);
	localparam logic [SAMPLE_W-1:0] ADC_OFFSET = SAMPLE_W'(1000);

	// APB register map, register i at byte address 4*i
	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_THRESHOLD  = 3'd0,
		REG_HYSTERESIS = 3'd1,
		REG_VALUE_STEP = 3'd2,
		REG_MIN_PULSE  = 3'd3,
		REG_MAX_PULSE  = 3'd4,
		REG_VALUE_EN   = 3'd5,
		REG_THRESH_EN  = 3'd6
	} reg_idx_t;

	// input kinds
	typedef enum logic [1:0] {
		KIND_EDGE   = 2'd0,
		KIND_DIRECT = 2'd1,
		KIND_ADC    = 2'd2,
		KIND_POLL   = 2'd3
	} kind_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EDGE  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_PUSH  = 7'b0001000,
		ST_SUM   = 7'b0010000,
		ST_EVAL  = 7'b0100000,
		ST_SCALE = 7'b1000000
	} state_t;

endpackage

FILE: sv/pwa_item_if.sv
// ----------------------------------------------------------------------------
// pwa_item_if - input request channel
// Valid/ready handshake carrying one pin edge, sample, converter code or poll.
// ----------------------------------------------------------------------------
interface pwa_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        level;
	logic [31:0] time_us;
	logic [15:0] sample_us;
	logic [11:0] adc_code;

	modport source (output valid, kind, level, time_us, sample_us, adc_code, input ready);
	modport sink   (input valid, kind, level, time_us, sample_us, adc_code, output ready);
endinterface

FILE: sv/pwa_result_if.sv
// ----------------------------------------------------------------------------
// pwa_result_if - result request channel
// Valid/ready handshake carrying the mean and the event flags.
// ----------------------------------------------------------------------------
interface pwa_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] mean_us;
	logic        sample_taken;
	logic        value_changed;
	logic        above;
	logic        above_changed;

	modport source (output valid, mean_us, sample_taken, value_changed, above, above_changed,
		input ready);
	modport sink   (input valid, mean_us, sample_taken, value_changed, above, above_changed,
		output ready);
endinterface

FILE: sv/pwm_pulse_averager_hysteresis_core.sv
// ----------------------------------------------------------------------------
// pwm_pulse_averager_hysteresis_core - pulse width capture with moving average
// Captures pulse widths, direct samples or converter codes into a ring,
// keeps the truncated mean, and reports mean changes and a hysteresis state.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             payload
//  item      in   valid/ready           kind, level, time_us, sample_us, adc_code
//  result    out  valid/ready           mean_us, sample_taken, value_changed,
//                                       above, above_changed
//  apb       in   psel/penable, pready  paddr[4:2] selects register, pwdata/prdata
//
//  Steps: a rising edge, a falling edge with no start, a zero direct sample
//  and a poll are accepted, then evaluated; a falling edge whose width is
//  rejected goes through the width check first. A kept direct sample is
//  accepted, pushed, then summed one ring entry per cycle over n entries, n
//  being the stored count (1..SAMPLE_DEPTH), then divided one quotient bit
//  per cycle in the shared restoring divider (DIV_W = 22 quotient bits at
//  depth 8), then evaluated. A kept pulse adds the width check. A converter
//  code is scaled in one extra step by a shift-and-add divide by 4095.
//  Reset: asynchronous, clears counts, start flag, reported mean, state and
//  the cached mean; ring contents need none as only written slots are summed.
//  Stalls: the result sits in an output register; a new request is taken
//  while it waits, and only the evaluate step holds until that register is
//  free.
//
module pwm_pulse_averager_hysteresis_core
	import pwa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	pwa_item_if.sink            item,
	pwa_result_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// ---------------- configuration registers ----------------
	logic [15:0] threshold_q;
	logic [15:0] hysteresis_q;
	logic [15:0] value_step_q;
	logic [15:0] min_pulse_q;
	logic [15:0] max_pulse_q;
	logic        value_en_q;
	logic        thresh_en_q;

	reg_idx_t    reg_idx;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[4:2]);
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= 16'd0;
			hysteresis_q <= 16'd0;
			value_step_q <= 16'd10;
			min_pulse_q  <= 16'd800;
			max_pulse_q  <= 16'd2200;
			value_en_q   <= 1'b0;
			thresh_en_q  <= 1'b0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_THRESHOLD:  threshold_q  <= pwdata[15:0];
				REG_HYSTERESIS: hysteresis_q <= pwdata[15:0];
				REG_VALUE_STEP: value_step_q <= pwdata[15:0];
				REG_MIN_PULSE:  min_pulse_q  <= pwdata[15:0];
				REG_MAX_PULSE:  max_pulse_q  <= pwdata[15:0];
				REG_VALUE_EN:   value_en_q   <= pwdata[0];
				REG_THRESH_EN:  thresh_en_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD:  prdata = {16'd0, threshold_q};
			REG_HYSTERESIS: prdata = {16'd0, hysteresis_q};
			REG_VALUE_STEP: prdata = {16'd0, value_step_q};
			REG_MIN_PULSE:  prdata = {16'd0, min_pulse_q};
			REG_MAX_PULSE:  prdata = {16'd0, max_pulse_q};
			REG_VALUE_EN:   prdata = {31'd0, value_en_q};
			REG_THRESH_EN:  prdata = {31'd0, thresh_en_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- datapath state ----------------
	state_t                state_q;
	logic [SAMPLE_W-1:0]   ring_q [SAMPLE_DEPTH];
	logic [SLOT_W-1:0]     slot_q;
	logic [COUNT_W-1:0]    count_q;
	logic [31:0]           start_time_q;
	logic                  start_valid_q;
	logic [SAMPLE_W-1:0]   reported_q;
	logic                  above_q;
	logic [SAMPLE_W-1:0]   mean_q;       // mean of the ring as it stands

	logic [31:0]           time_q;       // edge time of the request in hand
	logic [SAMPLE_W-1:0]   sample_q;     // value waiting to be pushed
	logic                  taken_q;
	logic                  eval_q;
	logic [COUNT_W-1:0]    sum_idx_q;
	logic [SUM_W-1:0]      acc_q;

	// shared restoring divider
	logic [DIV_W-1:0]      quo_q;
	logic [DVS_W-1:0]      rem_q;
	logic [DVS_W-1:0]      dvs_q;
	logic [DCNT_W-1:0]     div_cnt_q;
	logic [DVS_W:0]        rem_sh;
	logic                  div_ge;
	logic [DVS_W:0]        rem_nx;
	logic [DIV_W-1:0]      quo_nx;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign div_ge = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = div_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	assign quo_nx = {quo_q[DIV_W-2:0], div_ge};

	// converter scaling: quo_q holds code * 1000; x / (2^12 - 1) is
	// (x + (x >> 12) + 1) >> 12, exact while the quotient stays below 4096
	logic [DIV_W-1:0]      scale_sum;
	logic [SAMPLE_W-1:0]   adc_mapped;

	assign scale_sum  = quo_q + (quo_q >> ADC_W) + DIV_W'(1);
	assign adc_mapped = SAMPLE_W'(scale_sum[DIV_W-1:ADC_W]) + ADC_OFFSET;

	// pulse width, modulo 2^32
	logic [31:0]           width;
	logic                  width_ok;

	assign width    = time_q - start_time_q;
	assign width_ok = (width >= {16'd0, min_pulse_q}) && (width <= {16'd0, max_pulse_q});

	// summing pass
	logic [SAMPLE_W-1:0]   ring_rd;
	logic [SUM_W-1:0]      acc_nx;
	logic                  sum_last;

	assign ring_rd  = ring_q[sum_idx_q[SLOT_W-1:0]];
	assign acc_nx   = acc_q + SUM_W'(ring_rd);
	assign sum_last = COUNT_W'(sum_idx_q + 1'b1) == count_q;

	// evaluation
	logic [SAMPLE_W-1:0]   delta;
	logic                  changed;
	logic                  thresh_on;
	logic signed [17:0]    lower;
	logic [16:0]           upper;
	logic                  above_nx;
	logic                  out_free;

	assign delta    = (mean_q >= reported_q) ? (mean_q - reported_q) : (reported_q - mean_q);
	assign changed  = eval_q && value_en_q && (delta >= value_step_q);
	assign thresh_on = eval_q && thresh_en_q && (threshold_q != 16'd0);
	// threshold - hysteresis may go negative: then the state never clears
	assign lower    = $signed({2'b00, threshold_q}) - $signed({2'b00, hysteresis_q});
	assign upper    = {1'b0, threshold_q} + {1'b0, hysteresis_q};

	always_comb begin
		above_nx = above_q;
		if (thresh_on) begin
			if (above_q) begin
				if ($signed({2'b00, mean_q}) < lower)
					above_nx = 1'b0;
			end else begin
				if ({1'b0, mean_q} > upper)
					above_nx = 1'b1;
			end
		end
	end

	assign out_free   = !result.valid || result.ready;
	assign item.ready = state_q == ST_IDLE;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_q        <= '0;
			count_q       <= '0;
			start_time_q  <= 32'd0;
			start_valid_q <= 1'b0;
			reported_q    <= '0;
			above_q       <= 1'b0;
			mean_q        <= '0;
			taken_q       <= 1'b0;
			eval_q        <= 1'b0;
			sum_idx_q     <= '0;
			div_cnt_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						taken_q <= 1'b0;
						eval_q  <= (item.kind == KIND_POLL);
						time_q  <= item.time_us;
						case (kind_t'(item.kind))
							KIND_EDGE: begin
								if (item.level) begin
									start_time_q  <= item.time_us;
									start_valid_q <= 1'b1;
									state_q       <= ST_EVAL;
								end else if (start_valid_q) begin
									// start is dropped whether or not the width is kept
									start_valid_q <= 1'b0;
									state_q       <= ST_EDGE;
								end else begin
									state_q <= ST_EVAL;
								end
							end
							KIND_DIRECT: begin
								sample_q <= item.sample_us;
								state_q  <= (item.sample_us != 16'd0) ? ST_PUSH : ST_EVAL;
							end
							KIND_ADC: begin
								quo_q   <= DIV_W'(DIV_W'(item.adc_code) * ADC_SCALE);
								state_q <= ST_SCALE;
							end
							KIND_POLL: state_q <= ST_EVAL;
							default:   state_q <= ST_EVAL;
						endcase
					end
				end
				ST_EDGE: begin
					sample_q <= width[15:0];
					state_q  <= width_ok ? ST_PUSH : ST_EVAL;
				end
				ST_SCALE: begin
					sample_q <= adc_mapped;
					state_q  <= ST_PUSH;
				end
				ST_DIV: begin
					quo_q     <= quo_nx;
					rem_q     <= rem_nx[DVS_W-1:0];
					div_cnt_q <= DCNT_W'(div_cnt_q + 1'b1);
					if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
						mean_q  <= quo_nx[SAMPLE_W-1:0];
						state_q <= ST_EVAL;
					end
				end
				ST_PUSH: begin
					ring_q[slot_q] <= sample_q;
					slot_q  <= (slot_q == SLOT_W'(SAMPLE_DEPTH - 1)) ? '0 : SLOT_W'(slot_q + 1'b1);
					if (count_q < COUNT_W'(SAMPLE_DEPTH))
						count_q <= COUNT_W'(count_q + 1'b1);
					taken_q   <= 1'b1;
					eval_q    <= 1'b1;
					sum_idx_q <= '0;
					acc_q     <= '0;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					acc_q     <= acc_nx;
					sum_idx_q <= COUNT_W'(sum_idx_q + 1'b1);
					if (sum_last) begin
						quo_q     <= DIV_W'(acc_nx);
						rem_q     <= '0;
						dvs_q     <= DVS_W'(count_q);
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_EVAL: begin
					if (out_free) begin
						if (changed)
							reported_q <= mean_q;
						above_q <= above_nx;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- output register ----------------
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_mean_q;
	logic                out_taken_q;
	logic                out_changed_q;
	logic                out_above_q;
	logic                out_flip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EVAL && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && out_free) begin
			out_mean_q    <= mean_q;
			out_taken_q   <= taken_q;
			out_changed_q <= changed;
			out_above_q   <= above_nx;
			out_flip_q    <= above_nx != above_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.mean_us       = out_mean_q;
	assign result.sample_taken  = out_taken_q;
	assign result.value_changed = out_changed_q;
	assign result.above         = out_above_q;
	assign result.above_changed = out_flip_q;

endmodule
